@@ sv/epoch_seconds_to_calendar_macros.svh @@
// Assertion macros shared by the epoch-to-calendar RTL.
// Each use expects clk and rst_n in scope; define ASSERT_OFF to drop the checks.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define ETS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ETS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ETS_ASSERT_IMPL(lbl, ante, cons, msg)
`define ETS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/ets_pkg.sv @@
// Shared types, constants and tables for the epoch-to-calendar block.
// No dependencies; used by ets_front, ets_back and the top level through scoped names.
package ets_pkg;

  // Divider passes of the front end, in order.
  typedef enum logic [1:0] {
    PASS_SEC  = 2'd0,
    PASS_MIN  = 2'd1,
    PASS_HR   = 2'd2,
    PASS_WDAY = 2'd3
  } pass_t;

  // Time-of-day fields handed from front end to back end.
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hr;
    logic [2:0] wday;
  } tod_t;

  localparam logic [5:0] SEC_PER_MIN   = 6'd60;
  localparam logic [5:0] MIN_PER_HR    = 6'd60;
  localparam logic [5:0] HR_PER_DAY    = 6'd24;
  localparam logic [5:0] DAYS_PER_WEEK = 6'd7;
  localparam logic [3:0] EPOCH_WDAY    = 4'd4;   // 1970-01-01 was a Thursday

  // Year 1970 as years since 1900 and as residues for the leap rule.
  localparam logic [8:0] EPOCH_YEAR_OFS = 9'd70;
  localparam logic [1:0] EPOCH_MOD4     = 2'd2;
  localparam logic [6:0] EPOCH_MOD100   = 7'd70;
  localparam logic [8:0] EPOCH_MOD400   = 9'd370;
  localparam logic [6:0] LAST_MOD100    = 7'd99;
  localparam logic [8:0] LAST_MOD400    = 9'd399;

  localparam logic [8:0] DAYS_COMMON = 9'd365;
  localparam logic [8:0] DAYS_LEAP   = 9'd366;

  localparam logic [3:0] MON_JAN = 4'd0;
  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_DEC = 4'd11;

  function automatic logic [5:0] pass_divisor(input pass_t p);
    case (p)
      PASS_SEC:  pass_divisor = SEC_PER_MIN;
      PASS_MIN:  pass_divisor = MIN_PER_HR;
      PASS_HR:   pass_divisor = HR_PER_DAY;
      PASS_WDAY: pass_divisor = DAYS_PER_WEEK;
      default:   pass_divisor = DAYS_PER_WEEK;
    endcase
  endfunction

  // Days in a month of a common year.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd0:    month_len = 5'd31;
      4'd1:    month_len = 5'd28;
      4'd2:    month_len = 5'd31;
      4'd3:    month_len = 5'd30;
      4'd4:    month_len = 5'd31;
      4'd5:    month_len = 5'd30;
      4'd6:    month_len = 5'd31;
      4'd7:    month_len = 5'd31;
      4'd8:    month_len = 5'd30;
      4'd9:    month_len = 5'd31;
      4'd10:   month_len = 5'd30;
      4'd11:   month_len = 5'd31;
      default: month_len = 5'd31;
    endcase
  endfunction

endpackage

@@ sv/ets_if.sv @@
// Valid/ready channel interfaces for the epoch-to-calendar block.
// Input carries the seconds count, output the broken-down calendar fields.
interface ets_in_if #(
  parameter int SECONDS_WIDTH = 33
);
  logic                     valid;
  logic                     ready;
  logic [SECONDS_WIDTH-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ets_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [2:0] weekday;
  logic [8:0] years_since_1900;
  logic [8:0] day_of_year;
  logic [3:0] month_index;
  logic [4:0] day_of_month;

  modport source (
    output valid, output second, output minute, output hour, output weekday,
    output years_since_1900, output day_of_year, output month_index,
    output day_of_month, input ready
  );
  modport sink (
    input valid, input second, input minute, input hour, input weekday,
    input years_since_1900, input day_of_year, input month_index,
    input day_of_month, output ready
  );
endinterface

@@ sv/ets_front.sv @@
// Front end: accepts a seconds count and splits it into second, minute, hour,
// weekday and whole days by reciprocal multiplication. Uses ets_pkg, ets_in_if.
`include "epoch_seconds_to_calendar_macros.svh"

module ets_front #(
  parameter int SECONDS_WIDTH = 33
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ets_in_if.sink                    in_ch,
  output logic                      q_valid,
  input  logic                      q_ready,
  output ets_pkg::tod_t             q_tod,
  output logic [SECONDS_WIDTH-17:0] q_days
);

  localparam int DAYS_W = SECONDS_WIDTH - 16;
  localparam int HALF   = (SECONDS_WIDTH + 1) / 2;
  localparam int PRODW  = SECONDS_WIDTH + HALF;
  localparam int ACCW   = 2 * SECONDS_WIDTH;

  // floor(2^SECONDS_WIDTH / d): the estimate lands on the quotient or one below.
  localparam longint unsigned SPAN = 64'd1 << SECONDS_WIDTH;
  localparam logic [SECONDS_WIDTH-1:0] RECIP_SEC  = SECONDS_WIDTH'(SPAN / ets_pkg::SEC_PER_MIN);
  localparam logic [SECONDS_WIDTH-1:0] RECIP_MIN  = SECONDS_WIDTH'(SPAN / ets_pkg::MIN_PER_HR);
  localparam logic [SECONDS_WIDTH-1:0] RECIP_HR   = SECONDS_WIDTH'(SPAN / ets_pkg::HR_PER_DAY);
  localparam logic [SECONDS_WIDTH-1:0] RECIP_WDAY = SECONDS_WIDTH'(SPAN / ets_pkg::DAYS_PER_WEEK);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MLO  = 5'b00010,
    F_MHI  = 5'b00100,
    F_FIX  = 5'b01000,
    F_PUSH = 5'b10000
  } f_state_t;

  f_state_t                 state_r;
  ets_pkg::pass_t           pass_r;
  logic [SECONDS_WIDTH-1:0] quo_r;
  logic [ACCW-1:0]          acc_r;
  ets_pkg::tod_t            tod_r;
  logic [DAYS_W-1:0]        days_r;

  logic [5:0]               div_d;
  logic [SECONDS_WIDTH-1:0] recip;
  logic [HALF-1:0]          mul_b;
  logic [PRODW-1:0]         prod;
  logic [SECONDS_WIDTH-1:0] q_est;
  logic [6:0]               qd_lo;
  logic [6:0]               rem0;
  logic                     over;
  logic [5:0]               rem_nxt;
  logic [SECONDS_WIDTH-1:0] quo_nxt;
  logic [3:0]               wday_sum;
  logic [2:0]               wday_nxt;

  always_comb begin
    div_d = ets_pkg::pass_divisor(pass_r);
    case (pass_r)
      ets_pkg::PASS_SEC:  recip = RECIP_SEC;
      ets_pkg::PASS_MIN:  recip = RECIP_MIN;
      ets_pkg::PASS_HR:   recip = RECIP_HR;
      ets_pkg::PASS_WDAY: recip = RECIP_WDAY;
      default:            recip = RECIP_WDAY;
    endcase
    // Multiply by the low half of the reciprocal first, then by the high half.
    mul_b    = (state_r == F_MHI) ? HALF'(recip[SECONDS_WIDTH-1:HALF]) : recip[HALF-1:0];
    prod     = PRODW'(quo_r) * PRODW'(mul_b);
    q_est    = acc_r[ACCW-1:SECONDS_WIDTH];
    // The remainder of the estimate is below 2*d, so seven low bits hold it exactly.
    qd_lo    = q_est[6:0] * {1'b0, div_d};
    rem0     = quo_r[6:0] - qd_lo;
    over     = (rem0 >= {1'b0, div_d});
    rem_nxt  = over ? 6'(rem0 - {1'b0, div_d}) : rem0[5:0];
    quo_nxt  = over ? q_est + 1'b1 : q_est;
    wday_sum = {1'b0, rem_nxt[2:0]} + ets_pkg::EPOCH_WDAY;
    wday_nxt = (wday_sum >= ets_pkg::DAYS_PER_WEEK[3:0]) ?
               3'(wday_sum - ets_pkg::DAYS_PER_WEEK[3:0]) : wday_sum[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            quo_r   <= in_ch.epoch_seconds;
            pass_r  <= ets_pkg::PASS_SEC;
            state_r <= F_MLO;
          end
        end
        F_MLO: begin
          acc_r   <= ACCW'(prod);
          state_r <= F_MHI;
        end
        F_MHI: begin
          acc_r   <= acc_r + (ACCW'(prod) << HALF);
          state_r <= F_FIX;
        end
        F_FIX: begin
          // Quotient feeds the next pass; remainder is this pass's field.
          quo_r <= quo_nxt;
          case (pass_r)
            ets_pkg::PASS_SEC: begin
              tod_r.sec <= rem_nxt;
              pass_r    <= ets_pkg::PASS_MIN;
              state_r   <= F_MLO;
            end
            ets_pkg::PASS_MIN: begin
              tod_r.min <= rem_nxt;
              pass_r    <= ets_pkg::PASS_HR;
              state_r   <= F_MLO;
            end
            ets_pkg::PASS_HR: begin
              tod_r.hr <= rem_nxt[4:0];
              days_r   <= quo_nxt[DAYS_W-1:0];
              pass_r   <= ets_pkg::PASS_WDAY;
              state_r  <= F_MLO;
            end
            ets_pkg::PASS_WDAY: begin
              tod_r.wday <= wday_nxt;
              state_r    <= F_PUSH;
            end
            default: state_r <= F_IDLE;
          endcase
        end
        F_PUSH: begin
          if (q_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state_r == F_IDLE);
  assign q_valid     = (state_r == F_PUSH);
  assign q_tod       = tod_r;
  assign q_days      = days_r;

  `ETS_ASSERT_IMPL(a_rem_estimate, state_r == F_FIX, rem0 < {div_d, 1'b0}, "remainder estimate out of range")
  `ETS_ASSERT_NEXT(a_accept_starts_mul, in_ch.valid && in_ch.ready, (state_r == F_MLO) && (pass_r == ets_pkg::PASS_SEC), "accepted beat did not start")
  `ETS_ASSERT_NEXT(a_push_hold, q_valid && !q_ready, q_valid && (q_days == $past(q_days)), "waiting beat changed")

endmodule

@@ sv/ets_queue.sv @@
// Two-entry FIFO between the front and back ends of the calendar block.
// Generic flat payload; no package dependencies.
module ets_queue #(
  parameter int DATA_W = 37
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              push;
  logic              pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ sv/ets_back.sv @@
// Back end: walks whole years and then months off the day count, and holds
// the finished calendar beat in an output register. Uses ets_pkg, ets_out_if.
`include "epoch_seconds_to_calendar_macros.svh"

module ets_back #(
  parameter int SECONDS_WIDTH = 33
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  ets_pkg::tod_t             q_tod,
  input  logic [SECONDS_WIDTH-17:0] q_days,
  ets_out_if.source                 out_ch
);

  localparam int DAYS_W = SECONDS_WIDTH - 16;
  localparam int TW     = (DAYS_W > 9) ? DAYS_W : 9;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_YEAR  = 4'b0010,
    B_MONTH = 4'b0100,
    B_WRITE = 4'b1000
  } b_state_t;

  b_state_t      state_r;
  ets_pkg::tod_t tod_r;
  logic [TW-1:0] t_r;
  logic [8:0]    yrs_r;
  logic [1:0]    y4_r;
  logic [6:0]    y100_r;
  logic [8:0]    y400_r;
  logic [3:0]    mon_r;
  logic [8:0]    yday_r;
  logic [4:0]    mday_r;

  logic          out_valid_r;
  ets_pkg::tod_t out_tod_r;
  logic [8:0]    out_yrs_r;
  logic [8:0]    out_yday_r;
  logic [3:0]    out_mon_r;
  logic [4:0]    out_mday_r;

  logic          leap;
  logic [TW-1:0] year_len;
  logic          year_fits;
  logic [4:0]    mon_len;
  logic          mon_fits;
  logic          out_free;

  always_comb begin
    leap      = (y4_r == '0) && ((y100_r != '0) || (y400_r == '0));
    year_len  = TW'(leap ? ets_pkg::DAYS_LEAP : ets_pkg::DAYS_COMMON);
    year_fits = (t_r < year_len);
    mon_len   = ets_pkg::month_len(mon_r) +
                5'((mon_r == ets_pkg::MON_FEB) && leap);
    // After the year walk fewer than 366 days remain.
    mon_fits  = (t_r[8:0] < {4'd0, mon_len});
    out_free  = !out_valid_r || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == B_WRITE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            tod_r   <= q_tod;
            t_r     <= TW'(q_days);
            yrs_r   <= ets_pkg::EPOCH_YEAR_OFS;
            y4_r    <= ets_pkg::EPOCH_MOD4;
            y100_r  <= ets_pkg::EPOCH_MOD100;
            y400_r  <= ets_pkg::EPOCH_MOD400;
            mon_r   <= ets_pkg::MON_JAN;
            state_r <= B_YEAR;
          end
        end
        B_YEAR: begin
          if (year_fits) begin
            yday_r  <= t_r[8:0];
            state_r <= B_MONTH;
          end else begin
            // Drop one whole year and advance the leap-rule residues.
            t_r    <= t_r - year_len;
            yrs_r  <= yrs_r + 1'b1;
            y4_r   <= y4_r + 1'b1;
            y100_r <= (y100_r == ets_pkg::LAST_MOD100) ? '0 : y100_r + 1'b1;
            y400_r <= (y400_r == ets_pkg::LAST_MOD400) ? '0 : y400_r + 1'b1;
          end
        end
        B_MONTH: begin
          if (mon_fits) begin
            mday_r  <= t_r[4:0] + 1'b1;
            state_r <= B_WRITE;
          end else begin
            t_r   <= t_r - TW'(mon_len);
            mon_r <= mon_r + 1'b1;
          end
        end
        B_WRITE: begin
          if (out_free) begin
            out_tod_r   <= tod_r;
            out_yrs_r   <= yrs_r;
            out_yday_r  <= yday_r;
            out_mon_r   <= mon_r;
            out_mday_r  <= mday_r;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign q_ready                 = (state_r == B_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.second           = out_tod_r.sec;
  assign out_ch.minute           = out_tod_r.min;
  assign out_ch.hour             = out_tod_r.hr;
  assign out_ch.weekday          = out_tod_r.wday;
  assign out_ch.years_since_1900 = out_yrs_r;
  assign out_ch.day_of_year      = out_yday_r;
  assign out_ch.month_index      = out_mon_r;
  assign out_ch.day_of_month     = out_mday_r;

  `ETS_ASSERT_IMPL(a_month_in_range, state_r == B_MONTH, mon_r <= ets_pkg::MON_DEC, "month walk ran past December")
  `ETS_ASSERT_NEXT(a_year_step, (state_r == B_YEAR) && !year_fits, yrs_r == 9'($past(yrs_r) + 1'b1), "year count did not advance")
  `ETS_ASSERT_NEXT(a_write_loads_out, (state_r == B_WRITE) && out_free, out_valid_r && (state_r == B_IDLE), "finished beat not loaded")

endmodule

@@ sv/epoch_seconds_to_calendar.sv @@
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 UTC into
// broken-down UTC calendar time, one result beat per input beat, in order.
// The front end divides by 60, 60 and 24 and reduces the day count modulo 7,
// each step a reciprocal multiply split into a low-half and a high-half
// product plus a correction step; it takes a new seconds count only after
// its last result has entered the queue. The back end then removes one year
// per cycle from 1970 on and one month per cycle; at the default width the
// largest input falls in the year 2242. A two-beat queue sits between the
// two ends, so they overlap and the sustained rate is set by the slower of
// the two for the data at hand. The in_ch interface must be instantiated
// with the same SECONDS_WIDTH as this block.
module epoch_seconds_to_calendar #(
  parameter int SECONDS_WIDTH = 33
) (
  input  logic      clk,
  input  logic      rst_n,
  ets_in_if.sink    in_ch,
  ets_out_if.source out_ch
);

  localparam int DAYS_W = SECONDS_WIDTH - 16;
  localparam int TOD_W  = $bits(ets_pkg::tod_t);
  localparam int QW     = TOD_W + DAYS_W;

  logic              fq_valid;
  logic              fq_ready;
  ets_pkg::tod_t     fq_tod;
  logic [DAYS_W-1:0] fq_days;
  logic [QW-1:0]     fq_data;

  logic              qb_valid;
  logic              qb_ready;
  logic [QW-1:0]     qb_data;
  ets_pkg::tod_t     qb_tod;
  logic [DAYS_W-1:0] qb_days;

  ets_front #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_tod   (fq_tod),
    .q_days  (fq_days)
  );

  assign fq_data = {fq_tod, fq_days};

  ets_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  assign qb_tod  = qb_data[QW-1:DAYS_W];
  assign qb_days = qb_data[DAYS_W-1:0];

  ets_back #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_tod   (qb_tod),
    .q_days  (qb_days),
    .out_ch  (out_ch)
  );

endmodule
